// ----- src/idt_pkg.sv -----
// Shared types and constants of the identifier table with aging.
package idt_pkg;

	// Table geometry.
	localparam int ENTRIES = 64;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	// Field widths of the channels.
	localparam int KEY_W     = 30;
	localparam int STAMP_W   = 32;
	localparam int TIMEOUT_W = 16;
	localparam int SLOT_W    = 6;
	localparam int COUNT_W   = 7;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(300);

	// Item action codes.
	localparam logic ACT_OBSERVE = 1'b0;
	localparam logic ACT_SWEEP   = 1'b1;

	// One table entry as it travels around the ring.
	typedef struct packed {
		logic               valid;
		logic [KEY_W-1:0]   key;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

endpackage

// ----- src/idt_ifs.sv -----
// Channel interfaces of the identifier table: item, result and configuration.
interface idt_req_if import idt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               action;
	logic [KEY_W-1:0]   vessel_id;
	logic [STAMP_W-1:0] now;

	modport source(output valid, action, vessel_id, now, input ready);
	modport sink(input valid, action, vessel_id, now, output ready);
endinterface

interface idt_rsp_if import idt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               found;
	logic               inserted;
	logic               full_res;
	logic [SLOT_W-1:0]  slot;
	logic [COUNT_W-1:0] removed_count;
	logic [COUNT_W-1:0] occupancy;

	modport source(output valid, found, inserted, full_res, slot, removed_count, occupancy,
		input ready);
	modport sink(input valid, found, inserted, full_res, slot, removed_count, occupancy,
		output ready);
endinterface

interface idt_cfg_if import idt_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [TIMEOUT_W-1:0] data;

	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

// ----- src/idt_cell.sv -----
// One storage cell of the entry ring: holds one entry and passes it on when the ring shifts.
module idt_cell import idt_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   shift,
	input  entry_t d,
	output entry_t q
);

	logic               valid_q;
	logic [KEY_W-1:0]   key_q;
	logic [STAMP_W-1:0] stamp_q;

	// The valid bit is control state and clears at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= d.valid;
		end
	end

	// Key and stamp only matter while the entry is valid.
	always_ff @(posedge clk) begin
		if (shift) begin
			key_q   <= d.key;
			stamp_q <= d.stamp;
		end
	end

	assign q = '{valid: valid_q, key: key_q, stamp: stamp_q};

endmodule

// ----- src/id_table_with_aging.sv -----
// Top level of the identifier table with aging: entry ring, scan sequencer and result register.
//
// Channel | Dir | Transfer moves
// --------+-----+---------------------------------------------------------------
// req     | in  | action, vessel_id, now
// rsp     | out | found, inserted, full_res, slot, removed_count, occupancy
// cfg     | in  | data (timeout_seconds)
//
// The entries sit in a ring of ENTRIES cells that rotates one place per cycle in the scan and
// fill states past one head position, where the compare, age check and write-back happen.
// A sweep, a hit or a full miss goes from the scan state to the wait state; an observe that
// inserts takes a fill pass in between, the second rotation writing the new entry.
// Reset clears all valid bits at once; no clearing pass is needed.
// A new item is taken once the result has moved to the output register, so a stalled
// result holds back at most the following item's completion, not its acceptance.
module id_table_with_aging import idt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	idt_req_if.sink     req,
	idt_rsp_if.source   rsp,
	idt_cfg_if.sink     cfg
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FILL,
		S_WAIT
	} state_t;

	state_t               state_q;
	logic [IDX_W-1:0]     cnt_q;
	logic                 action_q;
	logic [KEY_W-1:0]     key_q;
	logic [STAMP_W-1:0]   now_q;
	logic [TIMEOUT_W-1:0] timeout_q;
	logic                 hit_q;
	logic [IDX_W-1:0]     hit_idx_q;
	logic                 free_q;
	logic [IDX_W-1:0]     free_idx_q;
	logic [CNT_W-1:0]     removed_q;
	logic [CNT_W-1:0]     occ_q;
	logic                 rsp_valid_q;

	entry_t               cell_q [ENTRIES];
	entry_t               head;
	entry_t               wb;
	logic                 shift;
	logic                 last;
	logic                 match;
	logic                 expire;
	logic [STAMP_W-1:0]   age;
	logic                 do_insert;
	logic                 inserted;
	logic [IDX_W-1:0]     res_idx;

	// Ring of cells: each takes its upper neighbor, the top cell takes the write-back.
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		entry_t d;
		if (i == ENTRIES - 1) begin : g_top
			assign d = wb;
		end else begin : g_mid
			assign d = cell_q[i+1];
		end
		idt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.d      (d),
			.q      (cell_q[i])
		);
	end

	// Head compare and age check for the entry whose index equals the step counter.
	assign head   = cell_q[0];
	assign shift  = (state_q == S_SCAN) || (state_q == S_FILL);
	assign last   = (cnt_q == IDX_W'(ENTRIES - 1));
	assign match  = head.valid && (head.key == key_q);
	assign age    = now_q - head.stamp;
	assign expire = head.valid && (age > STAMP_W'(timeout_q));

	// Write-back into the ring: refresh, expiry or the new entry.
	always_comb begin
		wb = head;
		if (state_q == S_SCAN) begin
			if (action_q == ACT_SWEEP) begin
				if (expire) begin
					wb.valid = 1'b0;
				end
			end else if (match) begin
				wb.stamp = now_q;
			end
		end else if (state_q == S_FILL && cnt_q == free_idx_q) begin
			wb = '{valid: 1'b1, key: key_q, stamp: now_q};
		end
	end

	// Result of the finished item.
	assign inserted = (action_q == ACT_OBSERVE) && !hit_q && free_q;
	assign do_insert = (state_q == S_FILL) && last;
	always_comb begin
		res_idx = '0;
		if (action_q == ACT_OBSERVE) begin
			if (hit_q) begin
				res_idx = hit_idx_q;
			end else if (free_q) begin
				res_idx = free_idx_q;
			end
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;

	// Timeout register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg.valid) begin
			timeout_q <= cfg.data;
		end
	end

	// Item capture, never reset.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			action_q <= req.action;
			key_q    <= req.vessel_id;
			now_q    <= req.now;
		end
	end

	// Sequencer, scan bookkeeping and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			hit_q       <= 1'b0;
			hit_idx_q   <= '0;
			free_q      <= 1'b0;
			free_idx_q  <= '0;
			removed_q   <= '0;
			occ_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// The result register fills from the wait state and empties on a transfer.
			if (state_q == S_WAIT && (!rsp_valid_q || rsp.ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q   <= S_SCAN;
						cnt_q     <= '0;
						hit_q     <= 1'b0;
						free_q    <= 1'b0;
						removed_q <= '0;
					end
				end
				S_SCAN: begin
					if (action_q == ACT_SWEEP) begin
						if (expire) begin
							removed_q <= removed_q + CNT_W'(1);
							occ_q     <= occ_q - CNT_W'(1);
						end
					end else begin
						if (match) begin
							hit_q     <= 1'b1;
							hit_idx_q <= cnt_q;
						end
						if (!head.valid && !free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= cnt_q;
						end
					end
					if (last) begin
						cnt_q <= '0;
						if (action_q == ACT_OBSERVE && !hit_q && !match
								&& (free_q || !head.valid)) begin
							state_q <= S_FILL;
						end else begin
							state_q <= S_WAIT;
						end
					end else begin
						cnt_q <= cnt_q + IDX_W'(1);
					end
				end
				S_FILL: begin
					if (do_insert) begin
						cnt_q   <= '0;
						occ_q   <= occ_q + CNT_W'(1);
						state_q <= S_WAIT;
					end else begin
						cnt_q <= cnt_q + IDX_W'(1);
					end
				end
				S_WAIT: begin
					if (!rsp_valid_q || rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output payload, loaded as the result leaves the wait state.
	always_ff @(posedge clk) begin
		if (state_q == S_WAIT && (!rsp_valid_q || rsp.ready)) begin
			rsp.found         <= (action_q == ACT_OBSERVE) && hit_q;
			rsp.inserted      <= inserted;
			rsp.full_res      <= (action_q == ACT_OBSERVE) && !hit_q && !free_q;
			rsp.slot          <= SLOT_W'(res_idx);
			rsp.removed_count <= COUNT_W'(removed_q);
			rsp.occupancy     <= COUNT_W'(occ_q);
		end
	end

endmodule

// ----- bench/idt_checker.sv -----
// Checker for the identifier table: mirrors the table from observed transfers and compares results.
module idt_checker import idt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	idt_req_if   req,
	idt_rsp_if   rsp,
	idt_cfg_if   cfg,
	output int   fail_count,
	output int   outstanding,
	output int   hit_count,
	output int   insert_count,
	output int   full_count,
	output int   aged_out_count
);
	timeunit 1ns;
	timeprecision 1ps;

	// One result as the table reports it.
	typedef struct packed {
		logic               found;
		logic               inserted;
		logic               full_res;
		logic [SLOT_W-1:0]  slot;
		logic [COUNT_W-1:0] removed_count;
		logic [COUNT_W-1:0] occupancy;
	} lookup_result_t;

	// Mirror of the table contents and of the timeout register.
	logic                 mirror_valid [ENTRIES];
	logic [KEY_W-1:0]     mirror_key   [ENTRIES];
	logic [STAMP_W-1:0]   mirror_stamp [ENTRIES];
	logic [TIMEOUT_W-1:0] mirror_timeout;

	lookup_result_t expected_results[$];
	int             reported;

	// Applies one item to the mirror and returns the result the table must give.
	function automatic lookup_result_t update_table(input logic act, input logic [KEY_W-1:0] id,
		input logic [STAMP_W-1:0] t);
		lookup_result_t res;
		logic [STAMP_W-1:0] age;
		int where;
		int occ;
		int i;
		res = '0;
		where = -1;
		occ = 0;
		if (act == ACT_OBSERVE) begin
			for (i = 0; i < ENTRIES; i++)
				if (where < 0 && mirror_valid[i] && mirror_key[i] == id)
					where = i;
			if (where >= 0) begin
				// Hit: refresh the stamp.
				mirror_stamp[where] = t;
				res.found = 1'b1;
				res.slot = SLOT_W'(where);
			end else begin
				// Miss: take the lowest free slot, if any.
				for (i = 0; i < ENTRIES; i++)
					if (where < 0 && !mirror_valid[i])
						where = i;
				if (where >= 0) begin
					mirror_valid[where] = 1'b1;
					mirror_key[where] = id;
					mirror_stamp[where] = t;
					res.inserted = 1'b1;
					res.slot = SLOT_W'(where);
				end else begin
					res.full_res = 1'b1;
				end
			end
		end else begin
			// Sweep: the age wraps modulo 2^32, so a future stamp looks very old.
			for (i = 0; i < ENTRIES; i++) begin
				if (mirror_valid[i]) begin
					age = t - mirror_stamp[i];
					if (age > STAMP_W'(mirror_timeout)) begin
						mirror_valid[i] = 1'b0;
						res.removed_count = res.removed_count + COUNT_W'(1);
					end
				end
			end
		end
		for (i = 0; i < ENTRIES; i++)
			if (mirror_valid[i])
				occ++;
		res.occupancy = COUNT_W'(occ);
		return res;
	endfunction

	// Track transfers on all three channels at the rising edge.
	always @(posedge clk or negedge arst_n) begin : track
		lookup_result_t want;
		lookup_result_t got;
		int i;
		if (!arst_n) begin
			for (i = 0; i < ENTRIES; i++)
				mirror_valid[i] = 1'b0;
			mirror_timeout = TIMEOUT_RESET;
			expected_results.delete();
			reported = 0;
			fail_count = 0;
			outstanding = 0;
			hit_count = 0;
			insert_count = 0;
			full_count = 0;
			aged_out_count = 0;
		end else begin
			// A result transfer is checked against the oldest prediction.
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.found, rsp.inserted, rsp.full_res, rsp.slot, rsp.removed_count,
					rsp.occupancy};
				if (expected_results.size() == 0) begin
					fail_count++;
					if (reported < 10) begin
						reported++;
						$display("[%0t] result transfer with no prediction waiting", $time);
					end
				end else begin
					want = expected_results.pop_front();
					hit_count += int'(want.found);
					insert_count += int'(want.inserted);
					full_count += int'(want.full_res);
					aged_out_count += int'(want.removed_count);
					if (got.found !== want.found || got.inserted !== want.inserted ||
						got.full_res !== want.full_res || got.slot !== want.slot ||
						got.removed_count !== want.removed_count ||
						got.occupancy !== want.occupancy) begin
						fail_count++;
						if (reported < 10) begin
							reported++;
							$display("[%0t] result differs", $time);
							$display("  want f=%0b i=%0b full=%0b slot=%0d rem=%0d occ=%0d",
								want.found, want.inserted, want.full_res, want.slot,
								want.removed_count, want.occupancy);
							$display("  got  f=%0b i=%0b full=%0b slot=%0d rem=%0d occ=%0d",
								got.found, got.inserted, got.full_res, got.slot,
								got.removed_count, got.occupancy);
						end
					end
				end
			end
			// An item transfer produces exactly one predicted result.
			if (req.valid && req.ready)
				expected_results.push_back(update_table(req.action, req.vessel_id, req.now));
			if (cfg.valid && cfg.ready)
				mirror_timeout = cfg.data;
			outstanding = expected_results.size();
		end
	end

endmodule

// ----- bench/tb_top.sv -----
// Testbench top of the identifier table: clock, reset, stimulus, flow control and verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import idt_pkg::*;

	localparam int PHASES          = 7;
	localparam int ITEMS_PER_PHASE = 98;
	localparam int TAIL_CYCLES     = 2 * ENTRIES + 20;
	localparam int CYCLE_LIMIT     = 1000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   steady;
	int   items_sent;
	int   sweeps_sent;
	int   cycles;

	int fail_count;
	int outstanding;
	int hit_count;
	int insert_count;
	int full_count;
	int aged_out_count;

	idt_req_if req();
	idt_rsp_if rsp();
	idt_cfg_if cfg();

	id_table_with_aging i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	idt_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req),
		.rsp            (rsp),
		.cfg            (cfg),
		.fail_count     (fail_count),
		.outstanding    (outstanding),
		.hit_count      (hit_count),
		.insert_count   (insert_count),
		.full_count     (full_count),
		.aged_out_count (aged_out_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Idle cycles before the next transfer; none during steady stretches.
	function automatic int draw_wait();
		return steady ? 0 : $urandom_range(0, 16);
	endfunction

	// Offers one item and returns once it has been transferred.
	task automatic send_item(input logic act, input logic [KEY_W-1:0] id,
		input logic [STAMP_W-1:0] t);
		int gap;
		gap = draw_wait();
		@(negedge clk);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.action <= act;
		req.vessel_id <= id;
		req.now <= t;
		do @(posedge clk); while (!req.ready);
		items_sent++;
		if (act == ACT_SWEEP)
			sweeps_sent++;
	endtask

	// Stops offering items and waits until every predicted result has arrived.
	task automatic drain();
		@(negedge clk);
		req.valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// Result side: random stalls before each transfer.
	initial begin : responder
		int stall;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_wait();
			@(negedge clk);
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
		end
	end

	// Watchdog on the total run length.
	initial begin : watchdog
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("id_table_with_aging: mismatch");
		$finish;
	end

	initial begin : stimulus
		logic [KEY_W-1:0]     pool [40];
		logic [STAMP_W-1:0]   clock_s;
		logic [TIMEOUT_W-1:0] timeout_val;
		int kind;
		int pool_size;
		int p;
		int n;
		int k;
		req.valid = 1'b0;
		req.action = ACT_OBSERVE;
		req.vessel_id = '0;
		req.now = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		steady = 1'b0;
		items_sent = 0;
		sweeps_sent = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part under the reset timeout: key extremes, refresh, boundary age,
		// future stamps, ignored key on sweeps and a sweep of an empty table.
		send_item(ACT_OBSERVE, KEY_W'(0), 32'd1000);
		send_item(ACT_OBSERVE, 30'h3FFF_FFFF, 32'd1000);
		send_item(ACT_OBSERVE, KEY_W'(999999999), 32'd1100);
		send_item(ACT_OBSERVE, KEY_W'(0), 32'd1200);
		send_item(ACT_OBSERVE, 30'h3FFF_FFFF, 32'd1250);
		send_item(ACT_SWEEP, 30'h2AAA_AAAA, 32'd1300);
		send_item(ACT_SWEEP, KEY_W'(0), 32'd1401);
		send_item(ACT_OBSERVE, 30'h1555_5555, 32'hFFFF_FFF0);
		send_item(ACT_OBSERVE, 30'h2AAA_AAAA, 32'd1500);
		send_item(ACT_SWEEP, KEY_W'(0), 32'd1500);
		send_item(ACT_OBSERVE, KEY_W'(999999999), 32'd1500);
		send_item(ACT_SWEEP, 30'h3FFF_FFFF, 32'hFFFF_FFFF);
		send_item(ACT_OBSERVE, 30'h3FFF_FFFF, 32'hFFFF_FFFF);
		send_item(ACT_OBSERVE, KEY_W'(1), 32'd0);
		send_item(ACT_SWEEP, KEY_W'(0), 32'h0000_0100);
		send_item(ACT_SWEEP, KEY_W'(0), 32'h0000_012C);
		send_item(ACT_OBSERVE, KEY_W'(1), 32'd300);
		send_item(ACT_SWEEP, KEY_W'(0), 32'd0);
		send_item(ACT_SWEEP, KEY_W'(0), 32'd0);

		// Random phases, each with its own timeout and key mix.
		clock_s = $urandom;
		for (p = 0; p < PHASES; p++) begin
			drain();
			case (p)
				0: timeout_val = '0;
				1: timeout_val = '1;
				2: timeout_val = 16'd20;
				3: timeout_val = TIMEOUT_RESET;
				4: timeout_val = TIMEOUT_W'($urandom);
				5: timeout_val = 16'd1000;
				default: timeout_val = 16'd3;
			endcase
			write_timeout(timeout_val);
			// Small pool gives many hits, medium pool a mix, fresh keys fill the table.
			kind = (p + 1) % 3;
			pool_size = (kind == 0) ? 6 : 40;
			for (k = 0; k < pool_size; k++)
				pool[k] = KEY_W'($urandom);
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n % 25 == 0)
					steady = ($urandom_range(0, 3) == 0);
				clock_s += $urandom_range(0, 40);
				if ($urandom_range(0, 29) == 0)
					clock_s += $urandom;
				if ($urandom_range(0, (kind == 2) ? 24 : 7) == 0)
					send_item(ACT_SWEEP, KEY_W'($urandom), clock_s);
				else if (kind == 2 || $urandom_range(0, 9) == 0)
					send_item(ACT_OBSERVE, KEY_W'($urandom), clock_s);
				else
					send_item(ACT_OBSERVE, pool[$urandom_range(0, pool_size - 1)], clock_s);
			end
		end

		// Let the last result arrive, then watch for stray transfers.
		steady = 1'b0;
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d items, %0d of them sweeps, over %0d timeout settings.",
			items_sent, sweeps_sent, PHASES + 1);
		$display("Results seen: %0d hits, %0d inserts, %0d full misses, %0d entries aged out.",
			hit_count, insert_count, full_count, aged_out_count);
		if (fail_count == 0 && outstanding == 0)
			$display("id_table_with_aging: match");
		else
			$display("id_table_with_aging: mismatch");
		$finish;
	end

endmodule
